>>> rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

	// Scan phase of the tokenizer
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WORD,
		PH_NUM,
		PH_COLON,
		PH_LESS,
		PH_GREATER,
		PH_EQUAL,
		PH_HALT
	} phase_t;

	// Token kinds as seen on the result channel
	typedef enum logic [4:0] {
		K_EOF,
		K_READ,
		K_WRITE,
		K_DO,
		K_OD,
		K_IF,
		K_FI,
		K_CHECK,
		K_IDENT,
		K_LITERAL,
		K_PLUS,
		K_MINUS,
		K_STAR,
		K_SLASH,
		K_LPAREN,
		K_RPAREN,
		K_ASSIGN,
		K_NE,
		K_LE,
		K_LT,
		K_GE,
		K_GT,
		K_EQ,
		K_ERROR
	} kind_t;

	// One token
	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [7:0]  length;
		logic        last;
	} result_t;

	// Up to two tokens caused by one request
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} res_pair_t;

	// Character codes
	localparam logic [7:0] CH_UNDERSCORE = "_";
	localparam logic [7:0] CH_EQUALS     = "=";
	localparam logic [7:0] CH_GREATER    = ">";
	localparam logic [7:0] CH_COLON      = ":";
	localparam logic [7:0] CH_LESS       = "<";
	localparam logic [7:0] CH_PLUS       = "+";
	localparam logic [7:0] CH_MINUS      = "-";
	localparam logic [7:0] CH_STAR       = "*";
	localparam logic [7:0] CH_SLASH      = "/";
	localparam logic [7:0] CH_LPAREN     = "(";
	localparam logic [7:0] CH_RPAREN     = ")";
	localparam logic [7:0] CH_SPACE      = " ";

	// Keywords, first character in the low byte
	localparam logic [31:0] KW_READ  = {"d", "a", "e", "r"};
	localparam logic [39:0] KW_WRITE = {"e", "t", "i", "r", "w"};
	localparam logic [15:0] KW_DO    = {"o", "d"};
	localparam logic [15:0] KW_OD    = {"d", "o"};
	localparam logic [15:0] KW_IF    = {"f", "i"};
	localparam logic [15:0] KW_FI    = {"i", "f"};
	localparam logic [39:0] KW_CHECK = {"k", "c", "e", "h", "c"};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Blank, tab, line feed, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

endpackage

>>> rtl/calculator_language_tokenizer_core.sv
`timescale 1ns / 1ps
// A request is held in the input register until the token queue has room, then scanned;
// its tokens are pushed into the queue, whose head is offered on out_valid.
// Throughput: one request per cycle while the queue is not full, set by the single-pass
// scan step; a request that yields two tokens offers them on the result port one by one.
// Input stalls only while the two-entry token queue is full.
// Reset: arst_n clears scan state, stream position, input register valid bit and token queue pointers.

module calculator_language_tokenizer_core import clt_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int POSITION_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [31:0] token_start,
	output logic [7:0]  token_length,
	output logic        last_of_run
);

	logic       v_s1, eoi_s1;
	logic [7:0] byte_s1;
	logic       q_full, advance, any;
	res_pair_t  pair;
	result_t    head_res;

	assign advance  = v_s1 && !q_full;
	assign in_ready = !v_s1 || !q_full;

	// Input register: hold the request until the queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			eoi_s1  <= req_type;
			byte_s1 <= data_byte;
		end
	end

	clt_step #(
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
		.POSITION_WIDTH  (POSITION_WIDTH)
	) u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (advance),
		.eoi   (eoi_s1),
		.ch    (byte_s1),
		.pair  (pair),
		.any   (any)
	);

	clt_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance && any),
		.push_pair(pair),
		.full     (q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head_res (head_res)
	);

	// Drive the result port from the queue head
	assign token_kind   = head_res.kind;
	assign token_start  = head_res.start;
	assign token_length = head_res.length;
	assign last_of_run  = head_res.last;

endmodule

>>> rtl/clt_step.sv
`timescale 1ns / 1ps

module clt_step import clt_pkg::*; #(
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int POSITION_WIDTH   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic       eoi,
	input  logic [7:0] ch,
	output res_pair_t  pair,
	output logic       any
);

	localparam int LEN_W  = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam int LEN_XW = (LEN_W > 8) ? LEN_W : 8;
	localparam int POS_XW = (POSITION_WIDTH > 32) ? POSITION_WIDTH : 32;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);

	phase_t                    phase_q, phase_d;
	logic [39:0]               prefix_q, prefix_d;
	logic [LEN_W-1:0]          len_q, len_d;
	logic [POSITION_WIDTH-1:0] start_q, start_d;
	logic [POSITION_WIDTH-1:0] pos_q, pos_d;

	logic [LEN_XW-1:0] len_x;
	logic [7:0]        len_sat;
	logic [POS_XW-1:0] start_x, pos_x;
	logic [31:0]       start32, pos32;
	kind_t             kw_kind;

	logic    e1, e2, rescan, do_append, do_begin;
	phase_t  begin_phase;
	result_t ra, rb;

	// Saturate the reported length and fit positions to the port
	assign len_x   = LEN_XW'(len_q);
	assign len_sat = (len_x > LEN_XW'(255)) ? 8'hFF : len_x[7:0];
	assign start_x = POS_XW'(start_q);
	assign pos_x   = POS_XW'(pos_q);
	assign start32 = start_x[31:0];
	assign pos32   = pos_x[31:0];

	// Keyword match at exact length
	always_comb begin
		priority if (len_q == LEN_W'(4) && prefix_q[31:0] == KW_READ) kw_kind = K_READ;
		else if (len_q == LEN_W'(5) && prefix_q == KW_WRITE) kw_kind = K_WRITE;
		else if (len_q == LEN_W'(2) && prefix_q[15:0] == KW_DO) kw_kind = K_DO;
		else if (len_q == LEN_W'(2) && prefix_q[15:0] == KW_OD) kw_kind = K_OD;
		else if (len_q == LEN_W'(2) && prefix_q[15:0] == KW_IF) kw_kind = K_IF;
		else if (len_q == LEN_W'(2) && prefix_q[15:0] == KW_FI) kw_kind = K_FI;
		else if (len_q == LEN_W'(5) && prefix_q == KW_CHECK) kw_kind = K_CHECK;
		else kw_kind = K_IDENT;
	end

	// Next state and tokens for one request
	always_comb begin
		phase_d     = phase_q;
		prefix_d    = prefix_q;
		len_d       = len_q;
		start_d     = start_q;
		pos_d       = pos_q;
		e1          = 1'b0;
		e2          = 1'b0;
		rescan      = 1'b0;
		do_append   = 1'b0;
		do_begin    = 1'b0;
		begin_phase = PH_IDLE;
		ra          = '{kind: K_IDENT, start: start32, length: len_sat, last: 1'b0};
		rb          = '{kind: K_EOF, start: pos32, length: 8'd1, last: 1'b1};

		if (go && phase_q != PH_HALT) begin
			if (eoi) begin
				// Flush the pending token, then end of file unless a lone colon or equals halts
				unique case (phase_q)
					PH_WORD: begin
						e1      = 1'b1;
						ra.kind = kw_kind;
					end
					PH_NUM: begin
						e1      = 1'b1;
						ra.kind = K_LITERAL;
					end
					PH_LESS: begin
						e1        = 1'b1;
						ra.kind   = K_LT;
						ra.length = 8'd1;
					end
					PH_GREATER: begin
						e1        = 1'b1;
						ra.kind   = K_GT;
						ra.length = 8'd1;
					end
					PH_COLON, PH_EQUAL: begin
						e1        = 1'b1;
						ra.kind   = K_ERROR;
						ra.length = 8'd1;
						phase_d   = PH_HALT;
					end
					PH_IDLE, PH_HALT: begin
					end
				endcase
				if (phase_q != PH_COLON && phase_q != PH_EQUAL) begin
					e2        = 1'b1;
					rb.kind   = K_EOF;
					rb.length = 8'd0;
					phase_d   = PH_IDLE;
					prefix_d  = '0;
					len_d     = '0;
				end
			end else begin
				pos_d = pos_q + POSITION_WIDTH'(1);
				unique case (phase_q)
					PH_IDLE: rescan = 1'b1;
					PH_WORD: begin
						if (is_letter(ch) || is_digit(ch) || ch == CH_UNDERSCORE) begin
							do_append = 1'b1;
						end else begin
							e1      = 1'b1;
							ra.kind = kw_kind;
							rescan  = 1'b1;
						end
					end
					PH_NUM: begin
						if (is_digit(ch)) begin
							do_append = 1'b1;
						end else begin
							e1      = 1'b1;
							ra.kind = K_LITERAL;
							rescan  = 1'b1;
						end
					end
					PH_LESS: begin
						e1 = 1'b1;
						priority if (ch == CH_GREATER) begin
							ra.kind   = K_NE;
							ra.length = 8'd2;
							phase_d   = PH_IDLE;
						end else if (ch == CH_EQUALS) begin
							ra.kind   = K_LE;
							ra.length = 8'd2;
							phase_d   = PH_IDLE;
						end else begin
							ra.kind   = K_LT;
							ra.length = 8'd1;
							rescan    = 1'b1;
						end
					end
					PH_GREATER: begin
						e1 = 1'b1;
						if (ch == CH_EQUALS) begin
							ra.kind   = K_GE;
							ra.length = 8'd2;
							phase_d   = PH_IDLE;
						end else begin
							ra.kind   = K_GT;
							ra.length = 8'd1;
							rescan    = 1'b1;
						end
					end
					PH_COLON, PH_EQUAL: begin
						e1 = 1'b1;
						if (ch == CH_EQUALS) begin
							ra.kind   = (phase_q == PH_COLON) ? K_ASSIGN : K_EQ;
							ra.length = 8'd2;
							phase_d   = PH_IDLE;
						end else begin
							// Lone colon or equals: drop this character and halt
							ra.kind   = K_ERROR;
							ra.length = 8'd1;
							phase_d   = PH_HALT;
						end
					end
					PH_HALT: begin
					end
				endcase

				// Scan the character as the start of a new token
				if (rescan) begin
					phase_d = PH_IDLE;
					priority if (is_space(ch)) begin
					end else if (is_letter(ch)) begin
						do_begin    = 1'b1;
						begin_phase = PH_WORD;
					end else if (is_digit(ch)) begin
						do_begin    = 1'b1;
						begin_phase = PH_NUM;
					end else begin
						unique case (ch)
							CH_PLUS: begin
								e2      = 1'b1;
								rb.kind = K_PLUS;
							end
							CH_MINUS: begin
								e2      = 1'b1;
								rb.kind = K_MINUS;
							end
							CH_STAR: begin
								e2      = 1'b1;
								rb.kind = K_STAR;
							end
							CH_SLASH: begin
								e2      = 1'b1;
								rb.kind = K_SLASH;
							end
							CH_LPAREN: begin
								e2      = 1'b1;
								rb.kind = K_LPAREN;
							end
							CH_RPAREN: begin
								e2      = 1'b1;
								rb.kind = K_RPAREN;
							end
							CH_COLON: begin
								do_begin    = 1'b1;
								begin_phase = PH_COLON;
							end
							CH_LESS: begin
								do_begin    = 1'b1;
								begin_phase = PH_LESS;
							end
							CH_GREATER: begin
								do_begin    = 1'b1;
								begin_phase = PH_GREATER;
							end
							CH_EQUALS: begin
								do_begin    = 1'b1;
								begin_phase = PH_EQUAL;
							end
							default: begin
								// Unknown character
								e2      = 1'b1;
								rb.kind = K_ERROR;
								phase_d = PH_HALT;
							end
						endcase
					end
				end

				// Extend the current word or number
				if (do_append) begin
					for (int k = 0; k < 5; k++) begin
						if (len_q == LEN_W'(k)) prefix_d[8*k +: 8] = ch;
					end
					if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
				end

				// Open a new token at this position
				if (do_begin) begin
					phase_d  = begin_phase;
					prefix_d = {32'd0, ch};
					len_d    = LEN_W'(1);
					start_d  = pos_q;
				end
			end
		end
	end

	// Order the tokens: pending one first
	always_comb begin
		pair.two         = e1 && e2;
		pair.first       = e1 ? ra : rb;
		pair.first.last  = !(e1 && e2);
		pair.second      = rb;
		pair.second.last = 1'b1;
		any              = e1 || e2;
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prefix_q <= '0;
			len_q    <= '0;
			start_q  <= '0;
			pos_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
			start_q  <= start_d;
			pos_q    <= pos_d;
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("halted tokenizer left halt");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> $stable(pos_q) && $stable(start_q))
		else $error("position moved while halted");

	a_tokens_need_go: assert property (@(posedge clk) disable iff (!arst_n)
		any |-> go && phase_q != PH_HALT)
		else $error("token produced without a request");

endmodule

>>> rtl/clt_out_queue.sv
`timescale 1ns / 1ps

module clt_out_queue import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  res_pair_t   push_pair,
	output logic        full,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     head_res
);

	res_pair_t   slot_q [2];
	logic        wr_ptr_q, rd_ptr_q, sel_q;
	logic [1:0]  cnt_q;
	res_pair_t   head;
	logic        pop_res, pop_entry;

	assign full      = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];
	assign head_res  = sel_q ? head.second : head.first;
	assign pop_res   = out_valid && out_ready;
	assign pop_entry = pop_res && (sel_q || !head.two);

	// Store a token pair
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_pair;
	end

	// Advance pointers, count and the token select within a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			sel_q    <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop_entry) rd_ptr_q <= !rd_ptr_q;
			if (pop_entry) sel_q <= 1'b0;
			else if (pop_res) sel_q <= 1'b1;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_entry};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("token pair written into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

	a_sel_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> out_valid && head.two)
		else $error("second token selected from a single-token entry");

endmodule

>>> tb/sv/clt_token_checker.sv
`timescale 1ns / 1ps

module clt_token_checker import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  token_kind,
	input  logic [31:0] token_start,
	input  logic [7:0]  token_length,
	input  logic        last_of_run,
	output int          mismatches,
	output int          outstanding
);

	localparam int MAX_LEN = 255;

	// Predicted tokenizer state
	phase_t      phase_q  = PH_IDLE;
	logic [39:0] prefix_q = '0;
	logic [7:0]  length_q = '0;
	logic [31:0] start_q  = '0;
	logic [31:0] pos_q    = '0;

	// Tokens caused by the request being scanned, and those still owed by the block
	result_t step_tokens[2];
	int      step_count;
	result_t pending_tokens[$];
	int      errs = 0;

	function automatic logic letter_code(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit_code(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic blank_code(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Keywords only match at their exact length
	function automatic kind_t keyword_or_ident(input logic [39:0] p, input logic [7:0] n);
		if (n == 8'd4 && p[31:0] == KW_READ)  return K_READ;
		if (n == 8'd5 && p == KW_WRITE)       return K_WRITE;
		if (n == 8'd2 && p[15:0] == KW_DO)    return K_DO;
		if (n == 8'd2 && p[15:0] == KW_OD)    return K_OD;
		if (n == 8'd2 && p[15:0] == KW_IF)    return K_IF;
		if (n == 8'd2 && p[15:0] == KW_FI)    return K_FI;
		if (n == 8'd5 && p == KW_CHECK)       return K_CHECK;
		return K_IDENT;
	endfunction

	function automatic void add_token(input kind_t k, input logic [31:0] s, input logic [7:0] l);
		step_tokens[step_count] = '{kind: k, start: s, length: l, last: 1'b0};
		step_count++;
	endfunction

	function automatic void open_token(input phase_t ph, input logic [7:0] c);
		phase_q  = ph;
		prefix_q = {32'b0, c};
		length_q = 8'd1;
		start_q  = pos_q;
	endfunction

	// Keep the first five characters; saturate the length
	function automatic void extend_token(input logic [7:0] c);
		if (length_q < 8'd5)
			prefix_q[8 * length_q +: 8] = c;
		if (length_q < MAX_LEN)
			length_q++;
	endfunction

	// Scan one request and queue the tokens it gives
	task automatic tokenize_step(input logic end_mark, input logic [7:0] c);
		logic rescan;
		step_count = 0;
		rescan     = 1'b1;
		if (phase_q == PH_HALT)
			return;
		if (end_mark) begin
			// flush the pending token, then end-of-file unless a lone ':' or '=' halts
			case (phase_q)
				PH_WORD:    add_token(keyword_or_ident(prefix_q, length_q), start_q, length_q);
				PH_NUM:     add_token(K_LITERAL, start_q, length_q);
				PH_LESS:    add_token(K_LT, start_q, 8'd1);
				PH_GREATER: add_token(K_GT, start_q, 8'd1);
				PH_COLON, PH_EQUAL: begin
					add_token(K_ERROR, start_q, 8'd1);
					phase_q = PH_HALT;
				end
				default: ;
			endcase
			if (phase_q != PH_HALT) begin
				add_token(K_EOF, pos_q, 8'd0);
				phase_q  = PH_IDLE;
				prefix_q = '0;
				length_q = '0;
			end
		end else begin
			// finish or extend the pending token
			case (phase_q)
				PH_WORD: begin
					if (letter_code(c) || digit_code(c) || c == CH_UNDERSCORE) begin
						extend_token(c);
						rescan = 1'b0;
					end else
						add_token(keyword_or_ident(prefix_q, length_q), start_q, length_q);
				end
				PH_NUM: begin
					if (digit_code(c)) begin
						extend_token(c);
						rescan = 1'b0;
					end else
						add_token(K_LITERAL, start_q, length_q);
				end
				PH_LESS: begin
					if (c == CH_GREATER) begin
						add_token(K_NE, start_q, 8'd2);
						rescan = 1'b0;
					end else if (c == CH_EQUALS) begin
						add_token(K_LE, start_q, 8'd2);
						rescan = 1'b0;
					end else
						add_token(K_LT, start_q, 8'd1);
				end
				PH_GREATER: begin
					if (c == CH_EQUALS) begin
						add_token(K_GE, start_q, 8'd2);
						rescan = 1'b0;
					end else
						add_token(K_GT, start_q, 8'd1);
				end
				PH_COLON, PH_EQUAL: begin
					// the character after a lone ':' or '=' is dropped
					rescan = 1'b0;
					if (c == CH_EQUALS)
						add_token((phase_q == PH_COLON) ? K_ASSIGN : K_EQ, start_q, 8'd2);
					else begin
						add_token(K_ERROR, start_q, 8'd1);
						phase_q = PH_HALT;
					end
				end
				default: ;
			endcase

			// start a new token with this character where it was not consumed
			if (phase_q != PH_HALT &&
			    (rescan || (phase_q != PH_WORD && phase_q != PH_NUM))) begin
				phase_q = PH_IDLE;
				if (rescan) begin
					if (blank_code(c))
						;
					else if (letter_code(c))
						open_token(PH_WORD, c);
					else if (digit_code(c))
						open_token(PH_NUM, c);
					else begin
						case (c)
							CH_PLUS:    add_token(K_PLUS, pos_q, 8'd1);
							CH_MINUS:   add_token(K_MINUS, pos_q, 8'd1);
							CH_STAR:    add_token(K_STAR, pos_q, 8'd1);
							CH_SLASH:   add_token(K_SLASH, pos_q, 8'd1);
							CH_LPAREN:  add_token(K_LPAREN, pos_q, 8'd1);
							CH_RPAREN:  add_token(K_RPAREN, pos_q, 8'd1);
							CH_COLON:   open_token(PH_COLON, c);
							CH_LESS:    open_token(PH_LESS, c);
							CH_GREATER: open_token(PH_GREATER, c);
							CH_EQUALS:  open_token(PH_EQUAL, c);
							default: begin
								add_token(K_ERROR, pos_q, 8'd1);
								phase_q = PH_HALT;
							end
						endcase
					end
				end
			end
			pos_q = pos_q + 32'd1;
		end

		if (step_count > 0)
			step_tokens[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			pending_tokens.push_back(step_tokens[i]);
	endtask

	task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
		errs++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// Predict on each accepted request, compare each accepted token
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				tokenize_step(req_type, data_byte);
			if (out_valid && out_ready) begin
				if (pending_tokens.size() == 0) begin
					errs++;
					$error("unexpected token: kind %0d start %0d length %0d",
					       token_kind, token_start, token_length);
				end else begin
					want = pending_tokens.pop_front();
					if (token_kind !== want.kind)
						flag("token_kind", want.kind, token_kind);
					if (token_start !== want.start)
						flag("token_start", want.start, token_start);
					if (token_length !== want.length)
						flag("token_length", want.length, token_length);
					if (last_of_run !== want.last)
						flag("last_of_run", want.last, last_of_run);
				end
			end
			mismatches  <= errs;
			outstanding <= pending_tokens.size();
		end
	end

endmodule

>>> tb/sv/tb_calculator_language_tokenizer_core.sv
`timescale 1ns / 1ps

module tb_calculator_language_tokenizer_core;
	import clt_pkg::*;

	localparam int N_ITEMS       = 650;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 60;
	localparam int SETTLE_CYCLES = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        req_type  = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [4:0]  token_kind;
	logic [31:0] token_start;
	logic [7:0]  token_length;
	logic        last_of_run;

	int mismatches;
	int outstanding;
	int sent  = 0;
	int quiet = 0;
	bit steady = 1'b0;

	string keywords[7] = '{"read", "write", "do", "od", "if", "fi", "check"};
	string pairs[5]    = '{":=", "<>", "<=", ">=", "=="};
	string singles     = "+-*/()";

	always #4 clk = ~clk;

	calculator_language_tokenizer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	clt_token_checker token_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] random_wordchar();
		int r;
		r = $urandom_range(0, 10);
		if (r == 10)
			return CH_UNDERSCORE;
		if (r < 4)
			return 8'("0" + $urandom_range(0, 9));
		return random_letter();
	endfunction

	// Blank, or one of tab through carriage return
	function automatic logic [7:0] random_blank();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? CH_SPACE : 8'(r);
	endfunction

	// Present one request after a random gap and hold it until taken
	task automatic offer(input logic end_mark, input logic [7:0] c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= end_mark;
		data_byte <= c;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic offer_text(input string s);
		for (int i = 0; i < s.len(); i++)
			offer(1'b0, s[i]);
	endtask

	// Drain tokens with random stalls, and one long hold-off to back the block up
	initial begin : drain
		int stall;
		int served;
		served = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (served == HOLD_AFTER)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			served++;
		end
	end

	initial begin : stimulus
		int         pick;
		int         k;
		int         len;
		int         long_at;
		bit         long_done;
		bit         after_rel;
		bit         rel;
		logic [7:0] c;

		long_done = 1'b0;
		after_rel = 1'b0;
		long_at   = $urandom_range(100, 400);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: pairs, keywords, identifier with underscore, literal ended by an operator,
		// end of input with extreme bytes, and a pending '<' flushed by end of input
		offer_text("do<>x_1:=42/(fi)>=y\t");
		offer(1'b1, 8'hFF);
		offer(1'b0, CH_LESS);
		offer(1'b1, 8'h00);

		// Random well-formed token stream, with tokens often run together
		while (sent < N_ITEMS) begin
			if (!long_done && sent >= long_at) begin
				// one token past the saturation length
				long_done = 1'b1;
				len = $urandom_range(256, 300);
				if ($urandom_range(0, 1)) begin
					offer(1'b0, random_letter());
					repeat (len - 1) offer(1'b0, random_wordchar());
				end else
					repeat (len) offer(1'b0, 8'("0" + $urandom_range(0, 9)));
			end

			rel  = 1'b0;
			pick = $urandom_range(0, 19);
			case (pick)
				0, 1, 2, 3:
					offer_text(keywords[$urandom_range(0, 6)]);
				4: begin
					// keyword one character too long or too short
					k = $urandom_range(0, 6);
					if ($urandom_range(0, 1)) begin
						offer_text(keywords[k]);
						offer(1'b0, random_wordchar());
					end else
						offer_text(keywords[k].substr(0, keywords[k].len() - 2));
				end
				5, 6, 7: begin
					offer(1'b0, random_letter());
					repeat ($urandom_range(0, 7)) offer(1'b0, random_wordchar());
				end
				8, 9, 10:
					repeat ($urandom_range(1, 6)) offer(1'b0, 8'("0" + $urandom_range(0, 9)));
				11, 12, 13:
					offer(1'b0, singles[$urandom_range(0, 5)]);
				14, 15, 16: begin
					// keep a lone '<' or '>' from swallowing the head of a pair
					k = $urandom_range(0, 4);
					if (after_rel && (pairs[k][0] == CH_EQUALS || pairs[k][0] == CH_GREATER))
						offer(1'b0, random_blank());
					offer_text(pairs[k]);
				end
				17: begin
					rel = 1'b1;
					offer(1'b0, $urandom_range(0, 1) ? CH_LESS : CH_GREATER);
				end
				18:
					offer(1'b1, 8'($urandom_range(0, 255)));
				default:
					repeat ($urandom_range(1, 3)) offer(1'b0, random_blank());
			endcase

			if ($urandom_range(0, 1)) begin
				offer(1'b0, random_blank());
				rel = 1'b0;
			end
			after_rel = rel;
			if ($urandom_range(0, 24) == 0)
				steady = ~steady;
		end

		// Halt the block by one of the error paths, then feed it more requests
		offer(1'b0, CH_SPACE);
		pick = $urandom_range(0, 3);
		case (pick)
			0: begin
				do c = 8'($urandom_range(0, 255));
				while ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
				       (c >= "0" && c <= "9") || c == CH_SPACE || (c >= 8'd9 && c <= 8'd13) ||
				       c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
				       c == CH_LPAREN || c == CH_RPAREN || c == CH_COLON ||
				       c == CH_LESS || c == CH_GREATER || c == CH_EQUALS);
				offer(1'b0, c);
			end
			1, 2: begin
				offer(1'b0, (pick == 1) ? CH_COLON : CH_EQUALS);
				do c = 8'($urandom_range(0, 255));
				while (c == CH_EQUALS);
				offer(1'b0, c);
			end
			default: begin
				offer(1'b0, $urandom_range(0, 1) ? CH_COLON : CH_EQUALS);
				offer(1'b1, 8'($urandom_range(0, 255)));
			end
		endcase
		repeat (4) offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		// Wait for every owed token, then a little longer for strays
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> calculator_language_tokenizer_core.f
rtl/clt_pkg.sv
rtl/clt_step.sv
rtl/clt_out_queue.sv
rtl/calculator_language_tokenizer_core.sv
tb/sv/clt_token_checker.sv
tb/sv/tb_calculator_language_tokenizer_core.sv
